// ===== rtl/tst_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Timer slot table package
// Shared constants, codes and structures of the timer slot table.
// ----------------------------------------------------------------------------
package tst_pkg;

	localparam int SLOTS = 16;
	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	typedef enum logic [2:0] {
		OP_REG    = 3'd0,
		OP_DEREG  = 3'd1,
		OP_CANCEL = 3'd2,
		OP_TICK   = 3'd3,
		OP_REAP   = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		KIND_REG   = 2'd0,
		KIND_FULL  = 2'd1,
		KIND_FIRED = 2'd2,
		KIND_DONE  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINAL
	} state_t;

	typedef struct packed {
		logic [31:0] fire;
		logic [15:0] rep;
		logic [7:0]  hid;
	} entry_t;

	// Write request into the slot table. valid is the new state of the slot's
	// valid bit; the data is stored only when the slot stays valid.
	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		logic             valid;
		entry_t           data;
	} tbl_wr_t;

	typedef struct packed {
		logic [31:0] sum;
		logic        eq;
		logic        lt;
	} alu_res_t;

endpackage
`default_nettype wire

// ===== rtl/tst_req_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Timer slot table request channel
// Valid/ready channel carrying one operation request per transaction.
// ----------------------------------------------------------------------------
interface tst_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  op;
	logic [31:0] now;
	logic [15:0] delay;
	logic [15:0] repeat_req;
	logic [7:0]  handler_id;
	logic [3:0]  slot;

	modport source (output valid, op, now, delay, repeat_req, handler_id, slot,
		input ready);
	modport sink (input valid, op, now, delay, repeat_req, handler_id, slot,
		output ready);
endinterface
`default_nettype wire

// ===== rtl/tst_rsp_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Timer slot table response channel
// Valid/ready channel carrying one result per transaction.
// ----------------------------------------------------------------------------
interface tst_rsp_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [3:0] slot_out;
	logic [7:0] handler_out;
	logic       last;

	modport source (output valid, kind, slot_out, handler_out, last, input ready);
	modport sink (input valid, kind, slot_out, handler_out, last, output ready);
endinterface
`default_nettype wire

// ===== rtl/tst_alu.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Timer slot table arithmetic unit
// Shared 32-bit adder and comparator used by the register, tick and reap scans.
// ----------------------------------------------------------------------------
module tst_alu import tst_pkg::*; (
	input  logic [31:0] base,
	input  logic [31:0] addend,
	input  logic [31:0] fire,
	output alu_res_t    res
);

	// Sums wrap modulo 2^32; the compares are unsigned.
	always_comb begin
		res.sum = base + addend;
		res.eq  = (fire == base);
		res.lt  = (fire < base);
	end

endmodule
`default_nettype wire

// ===== rtl/tst_table.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Timer slot table storage
// Slot memory with one write and one registered read port, plus a valid bit
// per slot so that reset frees every slot at once.
// ----------------------------------------------------------------------------
module tst_table import tst_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [IDX_W-1:0] rd_addr,
	output entry_t           rd_entry,
	input  tbl_wr_t          wr
);

	entry_t           mem_q [SLOTS];
	entry_t           rd_data_q;
	logic [IDX_W-1:0] rd_addr_q;
	logic [SLOTS-1:0] valid_q;

	always_ff @(posedge clk) begin
		if (wr.en && wr.valid) begin
			mem_q[wr.addr] <= wr.data;
		end
		rd_data_q <= mem_q[rd_addr];
		rd_addr_q <= rd_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr.en) begin
			valid_q[wr.addr] <= wr.valid;
		end
	end

	// A slot that is not valid reads as a free slot with all fields zero.
	assign rd_entry = valid_q[rd_addr_q] ? rd_data_q : '0;

endmodule
`default_nettype wire

// ===== rtl/timer_slot_table.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Timer slot table
// Table of timer slots with register, deregister, cancel, tick and reap.
// ----------------------------------------------------------------------------
// Every operation but cancel and an unknown operation walks the slot table
// one slot per cycle, while its scan does not stall, through a single read
// port and a shared adder/comparator; cancel goes straight to its slot.
// Register, deregister and cancel stop the scan at the slot they act on; an
// unknown operation or a cancel of a slot beyond the table skips the scan.
// A tick stalls its scan while a fired result waits to be taken, and a
// register waits at its free slot until its result can be issued. The block
// takes no new request until the final result of the current one is in its
// output register; that register is freed independently by the response side.
// ----------------------------------------------------------------------------
module timer_slot_table import tst_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	tst_req_if.sink   req,
	tst_rsp_if.source rsp
);

	state_t           state_q, state_d;
	kind_t            fin_kind_q, fin_kind_d;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic [2:0]       op_q;
	logic [31:0]      now_q;
	logic [15:0]      delay_q;
	logic [15:0]      rep_q;
	logic [7:0]       hid_q;

	logic             rsp_valid_q;
	kind_t            kind_q;
	logic [3:0]       slot_out_q;
	logic [7:0]       handler_q;
	logic             last_q;

	logic             can_emit;
	logic             emit;
	kind_t            emit_kind;
	logic [3:0]       emit_slot;
	logic [7:0]       emit_hid;
	logic             emit_last;
	logic             stall_scan;
	logic             last_slot;
	logic [31:0]      addend;
	entry_t           rd;
	alu_res_t         alu;
	tbl_wr_t          wr;

	tst_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (idx_d),
		.rd_entry(rd),
		.wr      (wr)
	);

	assign addend = (op_q == OP_TICK) ? {16'h0, rd.rep} : {16'h0, delay_q};

	tst_alu u_alu (
		.base  (now_q),
		.addend(addend),
		.fire  (rd.fire),
		.res   (alu)
	);

	assign req.ready = (state_q == ST_IDLE);
	assign can_emit  = !rsp_valid_q || rsp.ready;
	assign last_slot = (idx_q == IDX_W'(SLOTS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			fin_kind_q <= KIND_DONE;
			idx_q      <= '0;
		end else begin
			state_q    <= state_d;
			fin_kind_q <= fin_kind_d;
			idx_q      <= idx_d;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_q    <= req.op;
			now_q   <= req.now;
			delay_q <= req.delay;
			rep_q   <= req.repeat_req;
			hid_q   <= req.handler_id;
		end
	end

	always_comb begin
		state_d    = state_q;
		fin_kind_d = fin_kind_q;
		idx_d      = idx_q;
		emit       = 1'b0;
		emit_kind  = KIND_DONE;
		emit_slot  = 4'h0;
		emit_hid   = 8'h0;
		emit_last  = 1'b1;
		stall_scan = 1'b0;
		wr         = '0;
		wr.addr    = idx_q;

		unique case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					idx_d      = '0;
					fin_kind_d = KIND_DONE;
					unique case (req.op)
						OP_REG, OP_DEREG, OP_TICK, OP_REAP: begin
							state_d = ST_SCAN;
						end
						OP_CANCEL: begin
							if (int'(req.slot) < SLOTS) begin
								state_d = ST_SCAN;
								idx_d   = IDX_W'(req.slot);
							end else begin
								state_d = ST_FINAL;
							end
						end
						default: begin
							state_d = ST_FINAL;
						end
					endcase
				end
			end

			ST_SCAN: begin
				unique case (op_q)
					OP_REG: begin
						if (rd.fire == 32'h0) begin
							// The register result is the only result of this
							// transaction, so the slot is written as it is reported.
							if (can_emit) begin
								wr.en       = 1'b1;
								wr.valid    = 1'b1;
								wr.data     = '{fire: alu.sum, rep: rep_q, hid: hid_q};
								emit        = 1'b1;
								emit_kind   = KIND_REG;
								emit_slot   = 4'(idx_q);
								state_d     = ST_IDLE;
							end
						end else if (last_slot) begin
							fin_kind_d = KIND_FULL;
							state_d    = ST_FINAL;
						end else begin
							idx_d = idx_q + 1'b1;
						end
					end
					OP_DEREG: begin
						if (hid_q != 8'h0 && rd.hid == hid_q) begin
							wr.en    = 1'b1;
							wr.valid = 1'b0;
							state_d  = ST_FINAL;
						end else if (last_slot) begin
							state_d = ST_FINAL;
						end else begin
							idx_d = idx_q + 1'b1;
						end
					end
					OP_CANCEL: begin
						wr.en    = 1'b1;
						wr.valid = 1'b1;
						wr.data  = '{fire: rd.fire, rep: 16'h0, hid: rd.hid};
						state_d  = ST_FINAL;
					end
					OP_TICK: begin
						if (rd.fire != 32'h0 && alu.eq && !can_emit) begin
							stall_scan = 1'b1;
						end else begin
							if (rd.fire != 32'h0 && alu.eq) begin
								emit      = 1'b1;
								emit_kind = KIND_FIRED;
								emit_slot = 4'(idx_q);
								emit_hid  = rd.hid;
								emit_last = 1'b0;
								if (rd.rep != 16'h0) begin
									wr.en    = 1'b1;
									wr.valid = 1'b1;
									wr.data  = '{fire: alu.sum, rep: rd.rep, hid: rd.hid};
								end
							end
							if (last_slot) begin
								state_d = ST_FINAL;
							end else begin
								idx_d = idx_q + 1'b1;
							end
						end
					end
					OP_REAP: begin
						if (rd.fire != 32'h0 && alu.lt) begin
							wr.en    = 1'b1;
							wr.valid = 1'b0;
						end
						if (last_slot) begin
							state_d = ST_FINAL;
						end else begin
							idx_d = idx_q + 1'b1;
						end
					end
					default: begin
						state_d = ST_FINAL;
					end
				endcase
			end

			ST_FINAL: begin
				if (can_emit) begin
					emit      = 1'b1;
					emit_kind = fin_kind_q;
					state_d   = ST_IDLE;
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (emit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			kind_q     <= emit_kind;
			slot_out_q <= emit_slot;
			handler_q  <= emit_hid;
			last_q     <= emit_last;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.kind        = kind_q;
	assign rsp.slot_out    = slot_out_q;
	assign rsp.handler_out = handler_q;
	assign rsp.last        = last_q;

	// An accepted transaction always takes the sequencer out of the idle state in the next cycle.
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> (state_q != ST_IDLE))
		else $error("request accepted but sequencer stayed idle");

	// Only fired results come before the end of a transaction's results.
	a_only_fired_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.last) |-> (rsp.kind == KIND_FIRED))
		else $error("non-final result is not a fired result");

	// The table is only written while a scan is in progress.
	a_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> (state_q == ST_SCAN))
		else $error("slot table written outside a scan");

	// A stalled tick holds its slot until the fired result can be issued.
	a_stall_holds_slot: assert property (@(posedge clk) disable iff (!arst_n)
		stall_scan |=> ($stable(idx_q) && state_q == ST_SCAN))
		else $error("tick scan moved on while its result was pending");

endmodule
`default_nettype wire

// ===== tb/sv/tst_checker.sv =====
// ----------------------------------------------------------------------------
// Timer slot table checker
// Watches both channels of the timer slot table, keeps its own copy of the
// slot table, works out the results of each accepted request and compares
// every accepted result with the oldest one still due.
// ----------------------------------------------------------------------------
module tst_checker import tst_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	tst_req_if   req,
	tst_rsp_if   rsp,
	output int   mismatches,
	output int   outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SHOWN = 10;

	typedef struct packed {
		kind_t      kind;
		logic [3:0] slot;
		logic [7:0] handler;
		logic       last;
	} timer_event_t;

	logic [31:0]  fire_at [SLOTS];
	logic [15:0]  period  [SLOTS];
	logic [7:0]   owner   [SLOTS];
	timer_event_t due_events [$];
	timer_event_t want;
	int           bad = 0;

	function automatic timer_event_t event_of(kind_t kind, int idx, logic [7:0] handler,
		logic last);
		timer_event_t ev;
		ev.kind = kind;
		ev.slot = idx[3:0];
		ev.handler = handler;
		ev.last = last;
		return ev;
	endfunction

	task automatic clear_slot(input int idx);
		fire_at[idx] = '0;
		period[idx] = '0;
		owner[idx] = '0;
	endtask

	// Updates the table for one request and queues the results it causes.
	task automatic apply_timer_op(input logic [2:0] op, input logic [31:0] now,
		input logic [15:0] delay, input logic [15:0] rep, input logic [7:0] hid,
		input logic [3:0] sel);
		int hit;
		hit = -1;
		case (op)
		OP_REG: begin
			for (int i = 0; i < SLOTS; i++)
				if (hit < 0 && fire_at[i] == '0)
					hit = i;
			if (hit < 0) begin
				due_events.push_back(event_of(KIND_FULL, 0, '0, 1'b1));
			end else begin
				// A sum that wraps to zero leaves the slot free, yet it is reported.
				fire_at[hit] = now + 32'(delay);
				period[hit] = rep;
				owner[hit] = hid;
				due_events.push_back(event_of(KIND_REG, hit, '0, 1'b1));
			end
		end
		OP_DEREG: begin
			// A slot freed by a wrapped fire time keeps its handler id and can still be matched.
			if (hid != '0)
				for (int i = 0; i < SLOTS; i++)
					if (hit < 0 && owner[i] == hid)
						hit = i;
			if (hit >= 0)
				clear_slot(hit);
		end
		OP_CANCEL: begin
			if (int'(sel) < SLOTS)
				period[sel] = '0;
		end
		OP_TICK: begin
			for (int i = 0; i < SLOTS; i++)
				if (fire_at[i] != '0 && fire_at[i] == now) begin
					due_events.push_back(event_of(KIND_FIRED, i, owner[i], 1'b0));
					if (period[i] != '0)
						fire_at[i] = now + 32'(period[i]);
				end
		end
		OP_REAP: begin
			for (int i = 0; i < SLOTS; i++)
				if (fire_at[i] != '0 && fire_at[i] < now)
					clear_slot(i);
		end
		default: ;
		endcase
		if (op != OP_REG)
			due_events.push_back(event_of(KIND_DONE, 0, '0, 1'b1));
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++)
				clear_slot(i);
			due_events.delete();
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (due_events.size() == 0) begin
					if (bad < SHOWN)
						$display("unexpected result: kind %0d slot %0d handler 0x%02h last %0d",
							rsp.kind, rsp.slot_out, rsp.handler_out, rsp.last);
					bad++;
				end else begin
					want = due_events.pop_front();
					if (rsp.kind !== want.kind || rsp.slot_out !== want.slot ||
						rsp.handler_out !== want.handler || rsp.last !== want.last) begin
						if (bad < SHOWN)
							$display({"result mismatch: expected kind %0d slot %0d handler 0x%02h",
								" last %0d, got kind %0d slot %0d handler 0x%02h last %0d"},
								want.kind, want.slot, want.handler, want.last,
								rsp.kind, rsp.slot_out, rsp.handler_out, rsp.last);
						bad++;
					end
				end
			end
			if (req.valid && req.ready)
				apply_timer_op(req.op, req.now, req.delay, req.repeat_req, req.handler_id,
					req.slot);
		end
		mismatches = bad;
		outstanding = due_events.size();
	end

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// Timer slot table testbench
// Drives a directed run over the corner cases of the slot table, then random
// timelines of register, tick, cancel, deregister and reap requests plus
// table fill bursts, with random idling on both channels and one long
// response stall. The checker beside the block judges every result.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tst_pkg::*;

	localparam int          RANDOM_ITEMS = 340;
	localparam int          IDLE_PCT = 23;
	localparam int          HOLD_CYCLES = 400;
	localparam logic [2:0]  OP_SPARE_FIRST = 3'd5;
	localparam logic [2:0]  OP_SPARE_LAST = 3'd7;
	localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;

	logic clk;
	logic arst_n;
	logic calm;
	logic hold;
	int   mismatches;
	int   outstanding;
	int   sent = 0;
	int   first_random;

	logic [31:0] t;
	logic [31:0] nw;
	logic [15:0] dl;
	logic [15:0] rp;
	logic [7:0]  hd;
	logic [3:0]  sl;
	logic [2:0]  op;
	int          act;
	int          len;
	int          gap;

	tst_req_if req_ch();
	tst_rsp_if rsp_ch();

	timer_slot_table DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	tst_checker CHK (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	initial begin
		#(5_000_000);
		$display("FAIL");
		$finish;
	end

	function automatic logic [7:0] pick_handler();
		if ($urandom_range(0, 4) == 0)
			return 8'($urandom);
		return 8'($urandom_range(1, 6));
	endfunction

	// Offers one request and returns at the edge where the transaction completes.
	task automatic send_req(input logic [2:0] code, input logic [31:0] now,
		input logic [15:0] delay, input logic [15:0] rep, input logic [7:0] hid,
		input logic [3:0] sel);
		while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.op <= code;
		req_ch.now <= now;
		req_ch.delay <= delay;
		req_ch.repeat_req <= rep;
		req_ch.handler_id <= hid;
		req_ch.slot <= sel;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		sent++;
	endtask

	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			rsp_ch.ready <= !hold && (calm || $urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	// Long response stall so the block backs up onto the request channel.
	initial begin
		hold = 1'b0;
		wait (sent >= 90);
		@(posedge clk);
		hold <= 1'b1;
		repeat (HOLD_CYCLES)
			@(posedge clk);
		hold <= 1'b0;
	end

	initial begin
		arst_n = 1'b0;
		calm = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.op = '0;
		req_ch.now = '0;
		req_ch.delay = '0;
		req_ch.repeat_req = '0;
		req_ch.handler_id = '0;
		req_ch.slot = '0;
		repeat (3)
			@(posedge clk);
		arst_n <= 1'b1;

		send_req(OP_REAP, 32'd0, 16'd0, 16'd0, 8'h00, 4'd0);
		send_req(OP_TICK, 32'd0, 16'd0, 16'd0, 8'h00, 4'd0);
		// Both of these arm at time zero, so slot 0 is handed out twice.
		send_req(OP_REG, 32'd0, 16'd0, 16'd5, 8'h11, 4'd0);
		send_req(OP_REG, TIME_MAX, 16'd1, 16'hFFFF, 8'hFF, 4'hF);
		send_req(OP_DEREG, 32'd0, 16'd0, 16'd0, 8'hFF, 4'd0);
		send_req(OP_DEREG, 32'd0, 16'd0, 16'd0, 8'h00, 4'd0);
		send_req(OP_REG, 32'd100, 16'hFFFF, 16'hFFFF, 8'hAA, 4'd0);
		// The rearm of this one wraps to zero and frees the slot.
		send_req(OP_REG, 32'hFFFF_FFF0, 16'd8, 16'd8, 8'h01, 4'd0);
		send_req(OP_TICK, 32'hFFFF_FFF8, 16'd0, 16'd0, 8'h00, 4'd0);
		send_req(OP_REG, 32'd10, 16'd5, 16'd0, 8'h02, 4'd0);
		send_req(OP_TICK, 32'd15, 16'd0, 16'd0, 8'h00, 4'd0);
		send_req(OP_TICK, 32'd15, 16'd0, 16'd0, 8'h00, 4'd0);
		send_req(OP_REG, 32'd20, 16'd3, 16'd7, 8'h03, 4'd0);
		send_req(OP_CANCEL, 32'd0, 16'd0, 16'd0, 8'h00, 4'd2);
		send_req(OP_CANCEL, 32'd0, 16'd0, 16'd0, 8'h00, 4'hF);
		send_req(OP_TICK, 32'd23, 16'd0, 16'd0, 8'h00, 4'd0);
		// A fire time equal to now survives the reap.
		send_req(OP_REAP, 32'd23, 16'd0, 16'd0, 8'h00, 4'd0);
		send_req(OP_REG, 32'h55, 16'd0, 16'd2, 8'h04, 4'd0);
		send_req(OP_REG, 32'h50, 16'd5, 16'd0, 8'h05, 4'd0);
		send_req(OP_TICK, 32'h55, 16'd0, 16'd0, 8'h00, 4'd0);
		send_req(OP_SPARE_FIRST, 32'd0, 16'd0, 16'd0, 8'h00, 4'd0);
		send_req(OP_SPARE_LAST, TIME_MAX, 16'hFFFF, 16'hFFFF, 8'hFF, 4'hF);
		send_req(OP_REAP, TIME_MAX, 16'd0, 16'd0, 8'h00, 4'd0);
		send_req(OP_TICK, 32'h57, 16'd0, 16'd0, 8'h00, 4'd0);

		first_random = sent;
		while (sent < first_random + RANDOM_ITEMS) begin
			calm <= (sent - first_random >= 130 && sent - first_random < 210);
			if ($urandom_range(0, 9) == 0) begin
				// Fill burst: fill the table, often past its end, then fire most slots in one tick.
				t = $urandom;
				gap = $urandom_range(1, 20);
				send_req(OP_REAP, TIME_MAX, 16'($urandom), 16'($urandom), 8'($urandom),
					4'($urandom));
				len = $urandom_range(16, 19);
				for (int k = 0; k < len; k++) begin
					dl = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'(gap);
					rp = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(1, 9)) : 16'd0;
					send_req(OP_REG, t, dl, rp, pick_handler(), 4'($urandom));
				end
				send_req(OP_TICK, t + 32'(gap), 16'($urandom), 16'($urandom), 8'($urandom),
					4'($urandom));
				send_req(OP_TICK, t + 32'(gap), 16'($urandom), 16'($urandom), 8'($urandom),
					4'($urandom));
			end else begin
				// Timeline: mostly short delays and single-step ticks so timers really fire.
				case ($urandom_range(0, 5))
				0: t = $urandom_range(32'hFFFF_FFC0, 32'hFFFF_FFFF);
				1: t = $urandom_range(0, 40);
				default: t = $urandom;
				endcase
				if ($urandom_range(0, 1) == 1)
					send_req(OP_REAP, TIME_MAX, 16'($urandom), 16'($urandom), 8'($urandom),
						4'($urandom));
				len = $urandom_range(12, 40);
				for (int k = 0; k < len; k++) begin
					nw = $urandom;
					dl = 16'($urandom);
					rp = 16'($urandom);
					hd = 8'($urandom);
					sl = 4'($urandom);
					act = $urandom_range(0, 99);
					if (act < 32) begin
						op = OP_REG;
						nw = t;
						if ($urandom_range(0, 9) != 0)
							dl = 16'($urandom_range(0, 10));
						case ($urandom_range(0, 9))
						0, 1, 2, 3: rp = '0;
						9: ;
						default: rp = 16'($urandom_range(1, 6));
						endcase
						hd = pick_handler();
					end else if (act < 70) begin
						op = OP_TICK;
						nw = t;
					end else if (act < 78) begin
						op = OP_DEREG;
						if ($urandom_range(0, 3) != 0)
							hd = 8'($urandom_range(0, 6));
					end else if (act < 86) begin
						op = OP_CANCEL;
					end else if (act < 94) begin
						op = OP_REAP;
						nw = t - 32'($urandom_range(0, 4));
					end else begin
						op = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
					end
					send_req(op, nw, dl, rp, hd, sl);
					if (op == OP_TICK)
						t = t + (($urandom_range(0, 7) == 0) ? 32'($urandom_range(2, 5)) : 32'd1);
				end
			end
		end
		req_ch.valid <= 1'b0;
		calm <= 1'b0;

		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (2 * SLOTS + 4)
			@(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
